// ===== hw/rtl/tsfa_pkg.sv =====
// Shared constants, types and the UTF-8 step function for the text stream format analyser.
`timescale 1ns / 1ps

package tsfa_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned MAX_RES         = 4;
  localparam logic [31:0] MAX_EDIT_RESET  = 32'd16777216;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_MIN_A0,
    RULE_BELOW_A0,
    RULE_MIN_90,
    RULE_BELOW_90
  } rule_t;

  typedef struct packed {
    logic [1:0] cont;
    rule_t      rule;
    logic       err;
  } utf8_st_t;

  function automatic logic [7:0] bom_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      default: b = 8'hBF;
    endcase
    return b;
  endfunction

  function automatic utf8_st_t utf8_step(input utf8_st_t s, input logic [7:0] c);
    utf8_st_t n;
    logic     bad;
    n   = s;
    bad = 1'b0;
    if (!s.err) begin
      if (s.cont == 2'd0) begin
        n.rule = RULE_NONE;
        if (c < 8'h80) begin
          n.cont = 2'd0;
        end else if ((c & 8'hE0) == 8'hC0 && c >= 8'hC2) begin
          n.cont = 2'd1;
        end else if ((c & 8'hF0) == 8'hE0) begin
          n.cont = 2'd2;
          if (c == 8'hE0) begin
            n.rule = RULE_MIN_A0;
          end else if (c == 8'hED) begin
            n.rule = RULE_BELOW_A0;
          end
        end else if ((c & 8'hF8) == 8'hF0 && c <= 8'hF4) begin
          n.cont = 2'd3;
          if (c == 8'hF0) begin
            n.rule = RULE_MIN_90;
          end else if (c == 8'hF4) begin
            n.rule = RULE_BELOW_90;
          end
        end else begin
          n.err = 1'b1;
        end
      end else begin
        bad = ((c & 8'hC0) != 8'h80) ||
              (s.rule == RULE_MIN_A0   && c <  8'hA0) ||
              (s.rule == RULE_BELOW_A0 && c >= 8'hA0) ||
              (s.rule == RULE_MIN_90   && c <  8'h90) ||
              (s.rule == RULE_BELOW_90 && c >= 8'h90);
        n.rule = RULE_NONE;
        if (bad) begin
          n.err  = 1'b1;
          n.cont = 2'd0;
        end else begin
          n.cont = s.cont - 2'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/text_stream_format_analyser_top.sv =====
// Top level of the text stream format analyser: BOM strip, CR LF normalization, UTF-8 check.
`timescale 1ns / 1ps

// Raw file bytes enter one per beat; each input beat is fully evaluated in the cycle it is
// accepted and its results (zero to four: normalized text bytes, then one summary on the
// end-of-file beat) are loaded into a four-entry result buffer. The output channel drains
// that buffer one beat per cycle while out_stall is low, and a new input beat is taken in
// the same cycle as the last buffered result leaves. A held partial byte order mark or a
// held CR is released as the following byte or the end marker decides. Counters saturate
// at 2^COUNT_WIDTH-1 and are reported clipped to 32 bits. The user must write the size
// limit through the cfg port only while the block is idle; the block itself does not
// enforce it. The size limit resets to 16777216.

module text_stream_format_analyser_top
  import tsfa_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_text_byte,
  output logic        out_final_item,
  output logic        out_had_bom,
  output logic        out_mostly_crlf,
  output logic        out_utf8_ok,
  output logic        out_too_big,
  output logic [31:0] out_crlf_total,
  output logic [31:0] out_lf_total,
  output logic [31:0] out_raw_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_edit_bytes
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [31:0]            max_edit_r;
  logic [1:0]             bom_len_r, bom_len_nxt;
  logic                   bom_decided_r, bom_decided_nxt;
  logic                   bom_seen_r, bom_seen_nxt;
  logic                   cr_pending_r, cr_pending_nxt;
  logic [COUNT_WIDTH-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [COUNT_WIDTH-1:0] crlf_cnt_r, crlf_cnt_nxt;
  logic [COUNT_WIDTH-1:0] lf_cnt_r, lf_cnt_nxt;
  utf8_st_t               utf_r, utf_nxt;

  logic [7:0]             text_r [MAX_RES];
  logic [7:0]             text_nxt [MAX_RES];
  logic [2:0]             n_text_r, n_text_nxt;
  logic                   sum_r, sum_nxt;
  logic [2:0]             total_r;
  logic [1:0]             rd_idx_r;

  logic                   had_bom_r, had_bom_nxt;
  logic                   mostly_crlf_r, mostly_crlf_nxt;
  logic                   utf8_ok_r, utf8_ok_nxt;
  logic                   too_big_r, too_big_nxt;
  logic [31:0]            crlf_tot_r, crlf_tot_nxt;
  logic [31:0]            lf_tot_r, lf_tot_nxt;
  logic [31:0]            raw_tot_r, raw_tot_nxt;

  logic                   in_take;
  logic                   out_take;
  logic                   out_last;
  logic                   out_is_sum;

  function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] r;
    if (COUNT_WIDTH > 32 && (64'(v) >> 32) != 64'd0) begin
      r = '1;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  assign out_valid  = (total_r != 3'd0);
  assign out_last   = ({1'b0, rd_idx_r} == (total_r - 3'd1));
  assign out_take   = out_valid && !out_stall;
  assign in_stall   = out_valid && !(out_take && out_last);
  assign in_take    = in_valid && !in_stall;
  assign out_is_sum = sum_r && ({1'b0, rd_idx_r} == n_text_r);

  assign out_kind        = out_is_sum;
  assign out_text_byte   = out_is_sum ? 8'd0 : text_r[rd_idx_r];
  assign out_final_item  = out_last;
  assign out_had_bom     = out_is_sum & had_bom_r;
  assign out_mostly_crlf = out_is_sum & mostly_crlf_r;
  assign out_utf8_ok     = out_is_sum & utf8_ok_r;
  assign out_too_big     = out_is_sum & too_big_r;
  assign out_crlf_total  = out_is_sum ? crlf_tot_r : 32'd0;
  assign out_lf_total    = out_is_sum ? lf_tot_r : 32'd0;
  assign out_raw_total   = out_is_sum ? raw_tot_r : 32'd0;

  always_comb begin
    logic [7:0] feed [4];
    logic [1:0] n_feed;
    logic [1:0] m;
    logic [7:0] x;
    logic       crp;
    utf8_st_t   u;
    logic [2:0] nt;

    for (int k = 0; k < 4; k++) begin
      feed[k] = 8'd0;
    end
    for (int k = 0; k < MAX_RES; k++) begin
      text_nxt[k] = 8'd0;
    end
    n_feed          = 2'd0;
    nt              = 3'd0;
    x               = 8'd0;
    m               = (bom_len_r > 2'd2) ? 2'd2 : bom_len_r;
    bom_len_nxt     = bom_len_r;
    bom_decided_nxt = bom_decided_r;
    bom_seen_nxt    = bom_seen_r;
    byte_cnt_nxt    = byte_cnt_r;
    crlf_cnt_nxt    = crlf_cnt_r;
    lf_cnt_nxt      = lf_cnt_r;
    crp             = cr_pending_r;
    u               = utf_r;

    if (in_has_byte) begin
      byte_cnt_nxt = (byte_cnt_r == CNT_MAX) ? byte_cnt_r : byte_cnt_r + COUNT_WIDTH'(1);
      if (in_data_byte == CH_LF) begin
        if (cr_pending_r) begin
          crlf_cnt_nxt = (crlf_cnt_r == CNT_MAX) ? crlf_cnt_r
                                                 : crlf_cnt_r + COUNT_WIDTH'(1);
        end else begin
          lf_cnt_nxt = (lf_cnt_r == CNT_MAX) ? lf_cnt_r : lf_cnt_r + COUNT_WIDTH'(1);
        end
      end
      if (!bom_decided_r) begin
        if (in_data_byte == bom_byte(m)) begin
          if (m == 2'd2) begin
            bom_decided_nxt = 1'b1;
            bom_seen_nxt    = 1'b1;
            bom_len_nxt     = 2'd0;
          end else begin
            bom_len_nxt = m + 2'd1;
          end
        end else begin
          bom_decided_nxt = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (k < int'(bom_len_r)) begin
              feed[n_feed] = bom_byte(2'(k));
              n_feed       = n_feed + 2'd1;
            end
          end
          bom_len_nxt  = 2'd0;
          feed[n_feed] = in_data_byte;
          n_feed       = n_feed + 2'd1;
        end
      end else begin
        feed[n_feed] = in_data_byte;
        n_feed       = n_feed + 2'd1;
      end
    end

    if (in_end_of_file && !bom_decided_nxt) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(bom_len_nxt)) begin
          feed[n_feed] = bom_byte(2'(k));
          n_feed       = n_feed + 2'd1;
        end
      end
      bom_len_nxt = 2'd0;
    end

    for (int k = 0; k < 3; k++) begin
      if (k < int'(n_feed)) begin
        x = feed[k];
        if (crp) begin
          crp = 1'b0;
          if (x != CH_LF && nt < 3'(MAX_RES)) begin
            text_nxt[nt[1:0]] = CH_CR;
            u                 = utf8_step(u, CH_CR);
            nt                = nt + 3'd1;
          end
        end
        if (x == CH_CR) begin
          crp = 1'b1;
        end else if (nt < 3'(MAX_RES)) begin
          text_nxt[nt[1:0]] = x;
          u                 = utf8_step(u, x);
          nt                = nt + 3'd1;
        end
      end
    end

    if (in_end_of_file && crp) begin
      crp = 1'b0;
      if (nt < 3'(MAX_RES)) begin
        text_nxt[nt[1:0]] = CH_CR;
        u                 = utf8_step(u, CH_CR);
        nt                = nt + 3'd1;
      end
    end

    n_text_nxt      = nt;
    sum_nxt         = in_end_of_file && (nt < 3'(MAX_RES));
    had_bom_nxt     = bom_seen_nxt;
    mostly_crlf_nxt = crlf_cnt_nxt > lf_cnt_nxt;
    utf8_ok_nxt     = !u.err && (u.cont == 2'd0);
    too_big_nxt     = 64'(byte_cnt_nxt) > 64'(max_edit_r);
    crlf_tot_nxt    = clip32(crlf_cnt_nxt);
    lf_tot_nxt      = clip32(lf_cnt_nxt);
    raw_tot_nxt     = clip32(byte_cnt_nxt);

    cr_pending_nxt = crp;
    utf_nxt        = u;

    if (in_end_of_file) begin
      bom_len_nxt     = 2'd0;
      bom_decided_nxt = 1'b0;
      bom_seen_nxt    = 1'b0;
      cr_pending_nxt  = 1'b0;
      byte_cnt_nxt    = '0;
      crlf_cnt_nxt    = '0;
      lf_cnt_nxt      = '0;
      utf_nxt         = '{cont: 2'd0, rule: RULE_NONE, err: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_edit_r    <= MAX_EDIT_RESET;
      bom_len_r     <= 2'd0;
      bom_decided_r <= 1'b0;
      bom_seen_r    <= 1'b0;
      cr_pending_r  <= 1'b0;
      byte_cnt_r    <= '0;
      crlf_cnt_r    <= '0;
      lf_cnt_r      <= '0;
      utf_r         <= '{cont: 2'd0, rule: RULE_NONE, err: 1'b0};
      total_r       <= 3'd0;
      rd_idx_r      <= 2'd0;
      n_text_r      <= 3'd0;
      sum_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_edit_r <= cfg_max_edit_bytes;
      end
      if (in_take) begin
        bom_len_r     <= bom_len_nxt;
        bom_decided_r <= bom_decided_nxt;
        bom_seen_r    <= bom_seen_nxt;
        cr_pending_r  <= cr_pending_nxt;
        byte_cnt_r    <= byte_cnt_nxt;
        crlf_cnt_r    <= crlf_cnt_nxt;
        lf_cnt_r      <= lf_cnt_nxt;
        utf_r         <= utf_nxt;
        n_text_r      <= n_text_nxt;
        sum_r         <= sum_nxt;
        total_r       <= n_text_nxt + {2'd0, sum_nxt};
        rd_idx_r      <= 2'd0;
      end else if (out_take) begin
        if (out_last) begin
          total_r  <= 3'd0;
          rd_idx_r <= 2'd0;
        end else begin
          rd_idx_r <= rd_idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int k = 0; k < MAX_RES; k++) begin
        text_r[k] <= text_nxt[k];
      end
      had_bom_r     <= had_bom_nxt;
      mostly_crlf_r <= mostly_crlf_nxt;
      utf8_ok_r     <= utf8_ok_nxt;
      too_big_r     <= too_big_nxt;
      crlf_tot_r    <= crlf_tot_nxt;
      lf_tot_r      <= lf_tot_nxt;
      raw_tot_r     <= raw_tot_nxt;
    end
  end

endmodule
